/* sv/ups_ss_pkg.sv */
`default_nettype none

package ups_ss_pkg;

  localparam int CNT_W = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] POWER_OFF_DELAY_RST    = CNT_W'(30 * 1000);
  localparam logic [CNT_W-1:0] RESTORE_DELAY_RST      = CNT_W'(30 * 1000);
  localparam logic [CNT_W-1:0] STATUS_SETTLE_TIME_RST = CNT_W'(500);
  localparam logic [CNT_W-1:0] STATUS_PERIOD_RST      = CNT_W'(30 * 1000);
  localparam logic [CNT_W-1:0] WATCHDOG_LIMIT_RST     = CNT_W'(30 * 1000);

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POWER_OFF_DELAY    = 3'd0,
    CFG_RESTORE_DELAY      = 3'd1,
    CFG_STATUS_SETTLE_TIME = 3'd2,
    CFG_STATUS_PERIOD      = 3'd3,
    CFG_WATCHDOG_LIMIT     = 3'd4
  } cfg_index_t;

  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;

  // Only the first few characters of a line can take part in a match.
  localparam int CMP_DEPTH  = 6;
  localparam int SHUT_LEN   = 4;
  localparam int NOSHUT_LEN = 6;
  localparam int PING_LEN   = 4;

  localparam logic [8*SHUT_LEN-1:0]   CMD_SHUT   = "shut";
  localparam logic [8*NOSHUT_LEN-1:0] CMD_NOSHUT = "noshut";
  localparam logic [8*PING_LEN-1:0]   CMD_PING   = "ping";

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

`default_nettype wire

/* sv/ups_shutdown_supervisor.sv */
// An accepted word is held in the input register, and its result goes to the result register.
// Throughput: one word per cycle; the input register and the result register
// both move on every cycle the output side is not stalled.
// Reset (rst, synchronous, active high) restores the register defaults, clears all
// timers and flags, turns the UPS output flag on and empties both pipeline registers.
`default_nettype none

module ups_shutdown_supervisor
  import ups_ss_pkg::*;
#(
  parameter int LINE_DEPTH = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]       cfg_data,

  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   on_battery_level,
  input  wire logic                   mains_lost_level,
  input  wire logic                   battery_low_level,
  input  wire logic                   mains_ok_level,
  input  wire logic                   char_valid,
  input  wire logic [7:0]             char_code,

  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        status_report,
  output logic                        on_battery,
  output logic                        battery_low,
  output logic                        mains_lost,
  output logic                        mains_ok,
  output logic                        pong,
  output logic                        unrecognized,
  output logic                        watchdog_expired,
  output logic                        shutdown_pulse,
  output logic                        powerup_pulse,
  output logic                        ups_active
);

  localparam int LEN_W = $clog2(LINE_DEPTH + 1);

  logic [CNT_W-1:0] power_off_delay;
  logic [CNT_W-1:0] restore_delay;
  logic [CNT_W-1:0] status_settle_time;
  logic [CNT_W-1:0] status_period;
  logic [CNT_W-1:0] watchdog_limit;

  logic             s1_valid;
  logic             s1_on_battery_level;
  logic             s1_mains_lost_level;
  logic             s1_battery_low_level;
  logic             s1_mains_ok_level;
  logic             s1_char_valid;
  logic [7:0]       s1_char_code;

  logic [3:0]       status_flags;
  logic [CNT_W-1:0] status_elapsed;
  logic             report_pending;
  logic [CNT_W-1:0] watchdog_elapsed;
  logic             off_pending;
  logic [CNT_W-1:0] off_elapsed;
  logic             ups_on_flag;
  logic             restore_waiting;
  logic [CNT_W-1:0] restore_elapsed;
  logic [7:0]       line_buf [CMP_DEPTH];
  logic [LEN_W-1:0] line_length;

  logic [3:0]       status_flags_next;
  logic [CNT_W-1:0] status_elapsed_next;
  logic             report_pending_next;
  logic [CNT_W-1:0] watchdog_elapsed_next;
  logic             off_pending_next;
  logic [CNT_W-1:0] off_elapsed_next;
  logic             ups_on_flag_next;
  logic             restore_waiting_next;
  logic [CNT_W-1:0] restore_elapsed_next;
  logic [LEN_W-1:0] line_length_next;

  logic             store;
  logic             judge;
  logic             skip_restore;
  logic             mains_up_now;
  logic [3:0]       new_flags;
  logic [7:0]       eff_byte [CMP_DEPTH];

  logic             report_next;
  logic             pong_next;
  logic             unrec_next;
  logic             wd_next;
  logic             shut_next;
  logic             up_next;

  logic             out_free;
  logic             advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign advance   = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;

  always_comb begin
    status_elapsed_next   = bump(status_elapsed);
    watchdog_elapsed_next = bump(watchdog_elapsed);
    off_elapsed_next      = bump(off_elapsed);
    restore_elapsed_next  = bump(restore_elapsed);
    status_flags_next     = status_flags;
    report_pending_next   = report_pending;
    off_pending_next      = off_pending;
    ups_on_flag_next      = ups_on_flag;
    restore_waiting_next  = restore_waiting;
    line_length_next      = line_length;
    report_next           = 1'b0;
    pong_next             = 1'b0;
    unrec_next            = 1'b0;
    wd_next               = 1'b0;
    shut_next             = 1'b0;
    up_next               = 1'b0;
    skip_restore          = 1'b0;
    store                 = 1'b0;
    judge                 = 1'b0;

    new_flags = {~s1_mains_ok_level, ~s1_mains_lost_level,
                 ~s1_battery_low_level, s1_on_battery_level};
    if (new_flags != status_flags) begin
      status_flags_next   = new_flags;
      report_pending_next = 1'b1;
      status_elapsed_next = '0;
    end else if (status_elapsed_next > status_period) begin
      report_next         = 1'b1;
      report_pending_next = 1'b0;
      status_elapsed_next = '0;
    end
    if (report_pending_next && status_elapsed_next > status_settle_time) begin
      report_pending_next = 1'b0;
      report_next         = 1'b1;
      status_elapsed_next = '0;
    end
    mains_up_now = status_flags_next[3];

    if (s1_char_valid) begin
      if (s1_char_code == CHAR_LF || s1_char_code == CHAR_CR) begin
        judge = (line_length != '0);
      end else if (line_length < LEN_W'(LINE_DEPTH)) begin
        store            = 1'b1;
        line_length_next = line_length + LEN_W'(1);
        judge            = (line_length_next >= LEN_W'(LINE_DEPTH));
      end else begin
        judge = 1'b1;
      end
    end

    for (int i = 0; i < CMP_DEPTH; i++) begin
      eff_byte[i] = (store && line_length == LEN_W'(i)) ? fold(s1_char_code) : line_buf[i];
    end

    if (judge) begin
      if (line_length_next == LEN_W'(SHUT_LEN) &&
          {eff_byte[0], eff_byte[1], eff_byte[2], eff_byte[3]} == CMD_SHUT) begin
        watchdog_elapsed_next = '0;
        off_pending_next      = 1'b1;
        off_elapsed_next      = '0;
      end else if (line_length_next == LEN_W'(NOSHUT_LEN) &&
                   {eff_byte[0], eff_byte[1], eff_byte[2], eff_byte[3], eff_byte[4],
                    eff_byte[5]} == CMD_NOSHUT) begin
        watchdog_elapsed_next = '0;
        off_pending_next      = 1'b0;
      end else if (line_length_next == LEN_W'(PING_LEN) &&
                   {eff_byte[0], eff_byte[1], eff_byte[2], eff_byte[3]} == CMD_PING) begin
        pong_next             = 1'b1;
        watchdog_elapsed_next = '0;
      end else begin
        unrec_next = 1'b1;
      end
      line_length_next = '0;
    end

    if (!off_pending_next && watchdog_elapsed_next > watchdog_limit) begin
      wd_next          = 1'b1;
      off_pending_next = 1'b1;
      off_elapsed_next = '0;
    end

    if (off_pending_next) begin
      if (mains_up_now) begin
        off_pending_next = 1'b0;
        skip_restore     = 1'b1;
      end else if (off_elapsed_next > power_off_delay) begin
        shut_next        = 1'b1;
        off_pending_next = 1'b0;
        ups_on_flag_next = 1'b0;
      end
    end

    if (!skip_restore && !ups_on_flag_next && mains_up_now) begin
      if (!restore_waiting) begin
        restore_waiting_next = 1'b1;
        restore_elapsed_next = '0;
      end else if (restore_elapsed_next > restore_delay) begin
        up_next              = 1'b1;
        off_pending_next     = 1'b0;
        ups_on_flag_next     = 1'b1;
        restore_waiting_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_off_delay    <= POWER_OFF_DELAY_RST;
      restore_delay      <= RESTORE_DELAY_RST;
      status_settle_time <= STATUS_SETTLE_TIME_RST;
      status_period      <= STATUS_PERIOD_RST;
      watchdog_limit     <= WATCHDOG_LIMIT_RST;
      s1_valid           <= 1'b0;
      out_valid          <= 1'b0;
      status_flags       <= '0;
      status_elapsed     <= '0;
      report_pending     <= 1'b0;
      watchdog_elapsed   <= '0;
      off_pending        <= 1'b0;
      off_elapsed        <= '0;
      ups_on_flag        <= 1'b1;
      restore_waiting    <= 1'b0;
      restore_elapsed    <= '0;
      line_length        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POWER_OFF_DELAY:    power_off_delay    <= cfg_data;
          CFG_RESTORE_DELAY:      restore_delay      <= cfg_data;
          CFG_STATUS_SETTLE_TIME: status_settle_time <= cfg_data;
          CFG_STATUS_PERIOD:      status_period      <= cfg_data;
          CFG_WATCHDOG_LIMIT:     watchdog_limit     <= cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        out_valid        <= 1'b1;
        status_flags     <= status_flags_next;
        status_elapsed   <= status_elapsed_next;
        report_pending   <= report_pending_next;
        watchdog_elapsed <= watchdog_elapsed_next;
        off_pending      <= off_pending_next;
        off_elapsed      <= off_elapsed_next;
        ups_on_flag      <= ups_on_flag_next;
        restore_waiting  <= restore_waiting_next;
        restore_elapsed  <= restore_elapsed_next;
        line_length      <= line_length_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_on_battery_level  <= on_battery_level;
      s1_mains_lost_level  <= mains_lost_level;
      s1_battery_low_level <= battery_low_level;
      s1_mains_ok_level    <= mains_ok_level;
      s1_char_valid        <= char_valid;
      s1_char_code         <= char_code;
    end
    if (advance) begin
      for (int i = 0; i < CMP_DEPTH; i++) begin
        if (store && line_length == LEN_W'(i)) begin
          line_buf[i] <= fold(s1_char_code);
        end
      end
      status_report    <= report_next;
      on_battery       <= status_flags_next[0];
      battery_low      <= status_flags_next[1];
      mains_lost       <= status_flags_next[2];
      mains_ok         <= status_flags_next[3];
      pong             <= pong_next;
      unrecognized     <= unrec_next;
      watchdog_expired <= wd_next;
      shutdown_pulse   <= shut_next;
      powerup_pulse    <= up_next;
      ups_active       <= ups_on_flag_next;
    end
  end

endmodule

`default_nettype wire

/* sv/ups_ss_checker.sv */
`default_nettype none

module ups_ss_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic status_report,
  input wire logic pong,
  input wire logic unrecognized,
  input wire logic shutdown_pulse,
  input wire logic powerup_pulse,
  input wire logic ups_active
);

  // A stalled result word keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ups_active) && $stable(status_report)
      && $stable(shutdown_pulse) && $stable(powerup_pulse))
    else $error("stalled result word changed");

  // The word that carries the power-off pulse shows the output as off.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && shutdown_pulse |-> !ups_active)
    else $error("shutdown pulse with output still on");

  // The word that carries the restore pulse shows the output as on.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && powerup_pulse |-> ups_active)
    else $error("restore pulse with output still off");

  // A power-off and a restore never start in the same word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(shutdown_pulse && powerup_pulse))
    else $error("shutdown and restore pulses together");

  // A judged line is either answered or rejected, never both.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pong && unrecognized))
    else $error("pong and unrecognized together");

endmodule

bind ups_shutdown_supervisor ups_ss_checker u_ups_ss_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status_report  (status_report),
  .pong           (pong),
  .unrecognized   (unrecognized),
  .shutdown_pulse (shutdown_pulse),
  .powerup_pulse  (powerup_pulse),
  .ups_active     (ups_active)
);

`default_nettype wire
